// ===== design/vsrt_pkg.sv =====
// Shared types, register map and trigonometry table for the vertex transform.
package vsrt_pkg;

    localparam int ADDR_W  = 5;
    localparam int COORD_W = 32;
    localparam int ANGLE_W = 9;
    localparam int TRIG_IDX_W = 7;
    localparam int SIN_W   = 17;

    localparam logic [2:0] REG_X_SCALE = 3'd0;
    localparam logic [2:0] REG_Y_SCALE = 3'd1;
    localparam logic [2:0] REG_Z_SCALE = 3'd2;
    localparam logic [2:0] REG_ANGLE_X = 3'd3;
    localparam logic [2:0] REG_ANGLE_Y = 3'd4;
    localparam logic [2:0] REG_ANGLE_Z = 3'd5;
    localparam logic [2:0] REG_SHIFT_X = 3'd6;
    localparam logic [2:0] REG_SHIFT_Y = 3'd7;

    localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One word in flight: p and q are rotated, r rides along.
    typedef struct packed {
        logic   valid;
        coord_t p;
        coord_t q;
        coord_t r;
    } vsrt_item_t;

    // round(sin(d) * 65536) for d = 0..90 degrees.
    localparam logic [SIN_W-1:0] SIN_Q16 [0:90] = '{
        17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,
        17'd6850,  17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505,
        17'd13626, 17'd14742, 17'd15855, 17'd16962, 17'd18064, 17'd19161,
        17'd20252, 17'd21336, 17'd22415, 17'd23486, 17'd24550, 17'd25607,
        17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772,
        17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
        17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
        17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930,
        17'd48703, 17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339,
        17'd53020, 17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175,
        17'd56756, 17'd57319, 17'd57865, 17'd58393, 17'd58903, 17'd59396,
        17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584, 17'd61966,
        17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
        17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
        17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526,
        17'd65536
    };

    function automatic logic [SIN_W-1:0] sin_q16(input logic [TRIG_IDX_W-1:0] idx);
        logic [SIN_W-1:0] val;
        val = '0;
        if (idx <= TRIG_IDX_W'(90))
        begin
            val = SIN_Q16[idx];
        end
        return val;
    endfunction

    function automatic coord_t sat32(input logic signed [63:0] v);
        coord_t res;
        if (v > 64'sd2147483647)
        begin
            res = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            res = 32'sh80000000;
        end
        else
        begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/vsrt_rotate.sv =====
// Two-stage plane rotation of one coordinate pair by a whole-degree angle.
module vsrt_rotate
    import vsrt_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ANGLE_W-1:0] angle,
    input  vsrt_item_t         in_item,
    output vsrt_item_t         out_item
);

    localparam int CW      = TRIG_FRAC_BITS + 2;
    localparam int MAG_W   = TRIG_FRAC_BITS + 1;
    localparam int PW      = COORD_W + CW;
    localparam int TRIG_SH = 16 - TRIG_FRAC_BITS;
    localparam int TRIG_HALF = (TRIG_SH == 0) ? 0 : (1 << (TRIG_SH - 1));
    localparam int ROT_HALF  = 1 << (TRIG_FRAC_BITS - 1);
    localparam logic signed [CW-1:0] COEF_ONE = CW'(1 << TRIG_FRAC_BITS);

    logic [ANGLE_W-1:0]    ang_wrap;
    logic [ANGLE_W-1:0]    s_idx9;
    logic [ANGLE_W-1:0]    c_idx9;
    logic                  s_neg;
    logic                  c_neg;
    logic [SIN_W:0]        s_round;
    logic [SIN_W:0]        c_round;
    logic [MAG_W-1:0]      s_mag;
    logic [MAG_W-1:0]      c_mag;
    logic signed [CW-1:0]  sin_next;
    logic signed [CW-1:0]  cos_next;
    logic signed [CW-1:0]  sin_reg;
    logic signed [CW-1:0]  cos_reg;

    logic                  a_valid_reg;
    logic signed [PW-1:0]  pc_reg;
    logic signed [PW-1:0]  qs_reg;
    logic signed [PW-1:0]  ps_reg;
    logic signed [PW-1:0]  qc_reg;
    coord_t                r_reg;

    logic signed [63:0]    np_next;
    logic signed [63:0]    nq_next;
    logic                  out_valid_reg;
    coord_t                out_p_reg;
    coord_t                out_q_reg;
    coord_t                out_r_reg;

    // Fold the angle into the first quadrant and pick the signs.
    always_comb
    begin
        ang_wrap = (angle >= DEG_360) ? angle - DEG_360 : angle;
        s_neg = 1'b0;
        c_neg = 1'b0;
        if (ang_wrap < DEG_90)
        begin
            s_idx9 = ang_wrap;
            c_idx9 = DEG_90 - ang_wrap;
        end
        else if (ang_wrap < DEG_180)
        begin
            s_idx9 = DEG_180 - ang_wrap;
            c_idx9 = ang_wrap - DEG_90;
            c_neg  = 1'b1;
        end
        else if (ang_wrap < DEG_270)
        begin
            s_idx9 = ang_wrap - DEG_180;
            c_idx9 = DEG_270 - ang_wrap;
            s_neg  = 1'b1;
            c_neg  = 1'b1;
        end
        else
        begin
            s_idx9 = DEG_360 - ang_wrap;
            c_idx9 = ang_wrap - DEG_270;
            s_neg  = 1'b1;
        end
        s_round = {1'b0, sin_q16(s_idx9[TRIG_IDX_W-1:0])} + (SIN_W + 1)'(TRIG_HALF);
        c_round = {1'b0, sin_q16(c_idx9[TRIG_IDX_W-1:0])} + (SIN_W + 1)'(TRIG_HALF);
        s_mag = MAG_W'(s_round >> TRIG_SH);
        c_mag = MAG_W'(c_round >> TRIG_SH);
        sin_next = s_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
        cos_next = c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
    end

    always_comb
    begin
        np_next = (64'(pc_reg) - 64'(qs_reg) + 64'(ROT_HALF)) >>> TRIG_FRAC_BITS;
        nq_next = (64'(ps_reg) + 64'(qc_reg) + 64'(ROT_HALF)) >>> TRIG_FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg       <= '0;
            cos_reg       <= COEF_ONE;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sin_reg       <= sin_next;
            cos_reg       <= cos_next;
            a_valid_reg   <= in_item.valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg    <= PW'(in_item.p) * PW'(cos_reg);
        qs_reg    <= PW'(in_item.q) * PW'(sin_reg);
        ps_reg    <= PW'(in_item.p) * PW'(sin_reg);
        qc_reg    <= PW'(in_item.q) * PW'(cos_reg);
        r_reg     <= in_item.r;
        out_p_reg <= sat32(np_next);
        out_q_reg <= sat32(nq_next);
        out_r_reg <= r_reg;
    end

    assign out_item.valid = out_valid_reg;
    assign out_item.p     = out_p_reg;
    assign out_item.q     = out_q_reg;
    assign out_item.r     = out_r_reg;

    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_item.valid |-> ##2 out_item.valid)
        else $error("rotation dropped a word");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !in_item.valid |-> ##2 !out_item.valid)
        else $error("rotation produced a word from nothing");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        sin_reg <= COEF_ONE && sin_reg >= -COEF_ONE
        && cos_reg <= COEF_ONE && cos_reg >= -COEF_ONE)
        else $error("trig coefficient beyond unity");

    a_coef_not_both_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !(sin_reg == '0 && cos_reg == '0))
        else $error("sine and cosine both zero");

endmodule

// ===== design/vertex_scale_rotate_translate.sv =====
// Top level of the vertex transform: register port, scaling, rotations and offsets.
//
// Usage: load the scale, angle and offset registers over the APB port while
// no word is in flight, then pulse start with x_in, y_in and z_in once per
// point. busy is always low, so a new point may be given in every cycle.
// Each point is scaled per axis, rotated about Z, then X, then Y, offset in
// X and Y, and saturated to signed Q24.8 (COORD_FRAC_BITS fraction bits).
// The result appears on x_out, y_out and z_out with done high for exactly
// one cycle as the point leaves the last of the pipeline's nine register
// stages: scale multiply, rescale, two stages for each of the three
// rotations (multiply, then add and round), and the offset add.
// Throughput is one point per cycle.
// Reset returns the configuration registers to their reset values and clears the valid bits, emptying the pipeline.
// The receiver cannot stall; it must take each result in the cycle shown.
module vertex_scale_rotate_translate
    import vsrt_pkg::*;
#(
    parameter int TRIG_FRAC_BITS  = 14,
    parameter int COORD_FRAC_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    input  logic signed [15:0] z_in,
    output logic               done,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic signed [31:0] z_out
);

    localparam int LSH  = (COORD_FRAC_BITS > 8) ? COORD_FRAC_BITS - 8 : 0;
    localparam int RSH  = (COORD_FRAC_BITS < 8) ? 8 - COORD_FRAC_BITS : 0;
    localparam int HALF = (RSH == 0) ? 0 : (1 << (RSH - 1));
    localparam int PROD_W = 33;

    logic [15:0]         x_scale_reg;
    logic [15:0]         y_scale_reg;
    logic [15:0]         z_scale_reg;
    logic [ANGLE_W-1:0]  angle_x_reg;
    logic [ANGLE_W-1:0]  angle_y_reg;
    logic [ANGLE_W-1:0]  angle_z_reg;
    logic signed [15:0]  shift_x_reg;
    logic signed [15:0]  shift_y_reg;
    logic                cfg_write;
    logic [2:0]          cfg_idx;

    logic                      s1_valid_reg;
    logic signed [PROD_W-1:0]  x_prod_reg;
    logic signed [PROD_W-1:0]  y_prod_reg;
    logic signed [PROD_W-1:0]  z_prod_reg;
    logic                      s2_valid_reg;
    coord_t                    s2_x_reg;
    coord_t                    s2_y_reg;
    coord_t                    s2_z_reg;
    vsrt_item_t                s2_item;
    vsrt_item_t                rot_z_out;
    vsrt_item_t                rot_x_in;
    vsrt_item_t                rot_x_out;
    vsrt_item_t                rot_y_in;
    vsrt_item_t                rot_y_out;
    logic signed [63:0]        x_fin_next;
    logic signed [63:0]        y_fin_next;
    logic                      done_reg;
    coord_t                    x_out_reg;
    coord_t                    y_out_reg;
    coord_t                    z_out_reg;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg <= 16'd256;
            y_scale_reg <= 16'd256;
            z_scale_reg <= 16'd256;
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_X_SCALE: x_scale_reg <= pwdata[15:0];
                REG_Y_SCALE: y_scale_reg <= pwdata[15:0];
                REG_Z_SCALE: z_scale_reg <= pwdata[15:0];
                REG_ANGLE_X: angle_x_reg <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_Y: angle_y_reg <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_Z: angle_z_reg <= pwdata[ANGLE_W-1:0];
                REG_SHIFT_X: shift_x_reg <= pwdata[15:0];
                REG_SHIFT_Y: shift_y_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_X_SCALE: prdata = {16'd0, x_scale_reg};
            REG_Y_SCALE: prdata = {16'd0, y_scale_reg};
            REG_Z_SCALE: prdata = {16'd0, z_scale_reg};
            REG_ANGLE_X: prdata = {23'd0, angle_x_reg};
            REG_ANGLE_Y: prdata = {23'd0, angle_y_reg};
            REG_ANGLE_Z: prdata = {23'd0, angle_z_reg};
            REG_SHIFT_X: prdata = 32'(shift_x_reg);
            REG_SHIFT_Y: prdata = 32'(shift_y_reg);
            default:     prdata = '0;
        endcase
    end

    // Stage 1 multiplies by the scale; stage 2 brings the Q.8 product to
    // the output fraction width with round half up and saturates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= rot_y_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_prod_reg <= PROD_W'(x_in) * PROD_W'($signed({1'b0, x_scale_reg}));
        y_prod_reg <= PROD_W'(y_in) * PROD_W'($signed({1'b0, y_scale_reg}));
        z_prod_reg <= PROD_W'(z_in) * PROD_W'($signed({1'b0, z_scale_reg}));
        s2_x_reg   <= sat32(((64'(x_prod_reg) <<< LSH) + 64'(HALF)) >>> RSH);
        s2_y_reg   <= sat32(((64'(y_prod_reg) <<< LSH) + 64'(HALF)) >>> RSH);
        s2_z_reg   <= sat32(((64'(z_prod_reg) <<< LSH) + 64'(HALF)) >>> RSH);
        x_out_reg  <= sat32(x_fin_next);
        y_out_reg  <= sat32(y_fin_next);
        z_out_reg  <= rot_y_out.p;
    end

    assign s2_item.valid = s2_valid_reg;
    assign s2_item.p     = s2_x_reg;
    assign s2_item.q     = s2_y_reg;
    assign s2_item.r     = s2_z_reg;

    // About Z: (x, y) turn, z rides along.
    vsrt_rotate #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle    (angle_z_reg),
        .in_item  (s2_item),
        .out_item (rot_z_out)
    );

    // About X: (y, z) turn, x rides along.
    assign rot_x_in.valid = rot_z_out.valid;
    assign rot_x_in.p     = rot_z_out.q;
    assign rot_x_in.q     = rot_z_out.r;
    assign rot_x_in.r     = rot_z_out.p;

    vsrt_rotate #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle    (angle_x_reg),
        .in_item  (rot_x_in),
        .out_item (rot_x_out)
    );

    // About Y: (z, x) turn, y rides along.
    assign rot_y_in.valid = rot_x_out.valid;
    assign rot_y_in.p     = rot_x_out.q;
    assign rot_y_in.q     = rot_x_out.r;
    assign rot_y_in.r     = rot_x_out.p;

    vsrt_rotate #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle    (angle_y_reg),
        .in_item  (rot_y_in),
        .out_item (rot_y_out)
    );

    always_comb
    begin
        x_fin_next = 64'(rot_y_out.q) + (64'(shift_x_reg) <<< COORD_FRAC_BITS);
        y_fin_next = 64'(rot_y_out.r) + (64'(shift_y_reg) <<< COORD_FRAC_BITS);
    end

    assign done  = done_reg;
    assign x_out = x_out_reg;
    assign y_out = y_out_reg;
    assign z_out = z_out_reg;

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 9))
        else $error("result word without an accepted point");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##9 done)
        else $error("accepted point produced no result word");

    a_angle_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_idx == REG_ANGLE_X || cfg_idx == REG_ANGLE_Y || cfg_idx == REG_ANGLE_Z)
        |-> prdata[31:ANGLE_W] == '0)
        else $error("angle register reads back stray upper bits");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the vertex scale, rotate and translate pipeline.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vsrt_pkg::*;

    localparam int TRIG_FRAC    = 14;
    localparam int PIPE_LATENCY = 9;
    localparam int SETTLE       = PIPE_LATENCY + 3;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int POINTS_PER_PHASE = 100;

    // round(sin(d) * 65536) for whole degrees 0..90.
    localparam int SINE_Q16 [0:90] = '{
        0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
        11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vertex_t;

    typedef struct packed {
        bit                 is_write;
        logic [2:0]         idx;
        logic [31:0]        value;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        bit                 typed;
        vertex_t            want;
    } step_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] x_in = '0;
    logic signed [15:0] y_in = '0;
    logic signed [15:0] z_in = '0;
    logic               done;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;

    // Shadow copy of the register file.
    logic [15:0]        scale_x = 16'd256;
    logic [15:0]        scale_y = 16'd256;
    logic [15:0]        scale_z = 16'd256;
    logic [8:0]         angle_x = '0;
    logic [8:0]         angle_y = '0;
    logic [8:0]         angle_z = '0;
    logic signed [15:0] offset_x = '0;
    logic signed [15:0] offset_y = '0;

    vertex_t expected_points [$];
    vertex_t oldest;
    step_t   steps [$];
    bit      gaps_on = 1'b1;
    int      errors = 0;
    int      points_sent = 0;
    int      points_checked = 0;
    int      reg_writes = 0;
    int      stall_cycles = 0;

    vertex_scale_rotate_translate dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .x_in    (x_in),
        .y_in    (y_in),
        .z_in    (z_in),
        .done    (done),
        .x_out   (x_out),
        .y_out   (y_out),
        .z_out   (z_out)
    );

    always #2 clk = ~clk;

    function automatic longint clamp32(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    // Table entry brought from 16 to TRIG_FRAC fraction bits, rounding half up.
    function automatic longint trig_coef(input int d);
        return (longint'(SINE_Q16[d]) + (64'sd1 <<< (16 - TRIG_FRAC - 1))) >>> (16 - TRIG_FRAC);
    endfunction

    function automatic void sine_cosine(input logic [8:0] ang, output longint s,
                                        output longint c);
        int a;
        a = int'(ang);
        if (a >= 360)
        begin
            a = a - 360;
        end
        if (a < 90)
        begin
            s = trig_coef(a);
            c = trig_coef(90 - a);
        end
        else if (a < 180)
        begin
            s = trig_coef(180 - a);
            c = -trig_coef(a - 90);
        end
        else if (a < 270)
        begin
            s = -trig_coef(a - 180);
            c = -trig_coef(270 - a);
        end
        else
        begin
            s = -trig_coef(360 - a);
            c = trig_coef(a - 270);
        end
    endfunction

    function automatic void rotate_pair(inout longint p, inout longint q,
                                        input logic [8:0] ang);
        longint s;
        longint c;
        longint np;
        longint nq;
        sine_cosine(ang, s, c);
        np = (p * c - q * s + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        nq = (p * s + q * c + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        p = clamp32(np);
        q = clamp32(nq);
    endfunction

    function automatic vertex_t predict_vertex(input logic signed [15:0] px,
                                               input logic signed [15:0] py,
                                               input logic signed [15:0] pz);
        longint  x;
        longint  y;
        longint  z;
        vertex_t r;
        // Q8.8 scale of an integer gives Q.8 directly, the output format.
        x = clamp32(longint'(px) * longint'(scale_x));
        y = clamp32(longint'(py) * longint'(scale_y));
        z = clamp32(longint'(pz) * longint'(scale_z));
        rotate_pair(x, y, angle_z);
        rotate_pair(y, z, angle_x);
        rotate_pair(z, x, angle_y);
        x = clamp32(x + longint'(offset_x) * 256);
        y = clamp32(y + longint'(offset_y) * 256);
        r.x = 32'(x);
        r.y = 32'(y);
        r.z = 32'(z);
        return r;
    endfunction

    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        logic [31:0] m;
        case (idx)
            REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z: m = 32'h0000_01FF;
            default: m = 32'h0000_FFFF;
        endcase
        return m;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_X_SCALE: scale_x = value[15:0];
            REG_Y_SCALE: scale_y = value[15:0];
            REG_Z_SCALE: scale_z = value[15:0];
            REG_ANGLE_X: angle_x = value[8:0];
            REG_ANGLE_Y: angle_y = value[8:0];
            REG_ANGLE_Z: angle_z = value[8:0];
            REG_SHIFT_X: offset_x = value[15:0];
            REG_SHIFT_Y: offset_y = value[15:0];
            default: ;
        endcase
    endfunction

    // Write one register, then read it back and leave the bus idle.
    task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] got;
        logic [31:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        store_reg(idx, value);
        reg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        mask = reg_mask(idx);
        if ((got & mask) !== (value & mask))
        begin
            $error("register %0d readback: expected %0h, got %0h", idx, value & mask,
                   got & mask);
            errors++;
        end
        @(posedge clk);
    endtask

    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic signed [15:0] pz, input vertex_t want);
        while (gaps_on && $urandom_range(0, 99) < 25)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        x_in  <= px;
        y_in  <= py;
        z_in  <= pz;
        do @(posedge clk); while (busy !== 1'b0);
        expected_points.push_back(want);
        points_sent++;
    endtask

    // Let every word in flight come out before the registers change.
    task automatic drain();
        start <= 1'b0;
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_scale();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: v = 16'd0;
            1: v = 16'hFFFF;
            2: v = 16'd256;
            3: v = 16'd1;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic [8:0] pick_angle();
        logic [8:0] v;
        case ($urandom_range(0, 5))
            0: v = 9'(90 * $urandom_range(0, 3));
            1: v = 9'd359;
            2: v = 9'($urandom_range(360, 511));
            default: v = 9'($urandom_range(0, 359));
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_shift();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'h0000;
            3: v = 16'($signed($urandom_range(0, 200)) - 100);
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] pick_coord();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: v = 16'($urandom_range(0, 2)) - 16'sd1;
            3, 4: v = 16'($signed($urandom_range(0, 600)) - 300);
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Every result is matched against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result: x_out %0d, y_out %0d, z_out %0d",
                       x_out, y_out, z_out);
                errors++;
            end
            else
            begin
                oldest = expected_points.pop_front();
                if (x_out !== oldest.x)
                begin
                    $error("x_out mismatch: expected %0d, got %0d", oldest.x, x_out);
                    errors++;
                end
                if (y_out !== oldest.y)
                begin
                    $error("y_out mismatch: expected %0d, got %0d", oldest.y, y_out);
                    errors++;
                end
                if (z_out !== oldest.z)
                begin
                    $error("z_out mismatch: expected %0d, got %0d", oldest.z, z_out);
                    errors++;
                end
                points_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 ||
            (psel === 1'b1 && penable === 1'b1 && pready === 1'b1))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        step_t   st;
        vertex_t want;

        // Reset values: unit scale, no rotation, no offset, so output is input in Q.8.
        steps.push_back('{0, 3'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 1, '{32'sd0, 32'sd0, 32'sd0}});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd32767, -16'sd32768, 16'sd1, 1,
                          '{32'sd8388352, -32'sd8388608, 32'sd256}});
        steps.push_back('{0, 3'd0, 32'd0, -16'sd1, -16'sd32768, 16'sd32767, 1,
                          '{-32'sd256, -32'sd8388608, 32'sd8388352}});
        steps.push_back('{0, 3'd0, 32'd0, 16'sh5555, 16'shAAAA, -16'sd1, 0, '0});
        // A quarter turn about Z swaps X and Y with a sign change.
        steps.push_back('{1, REG_ANGLE_Z, 32'd90, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd1000, 16'sd2000, 16'sd3, 1,
                          '{-32'sd512000, 32'sd256000, 32'sd768}});
        steps.push_back('{1, REG_ANGLE_Z, 32'd180, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, -16'sd1234, 16'sd567, 16'sd89, 0, '0});
        steps.push_back('{1, REG_ANGLE_Z, 32'd270, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd32767, 16'sd32767, -16'sd32768, 0, '0});
        // Angles of 360 and above wrap back by a full turn.
        steps.push_back('{1, REG_ANGLE_Z, 32'd511, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd12345, -16'sd23456, 16'sd345, 0, '0});
        steps.push_back('{1, REG_ANGLE_Z, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_X, 32'd90, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd5, 16'sd6, -16'sd7, 0, '0});
        steps.push_back('{1, REG_ANGLE_X, 32'd359, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_Y, 32'd90, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, -16'sd32768, -16'sd32768, -16'sd32768, 0, '0});
        steps.push_back('{1, REG_ANGLE_X, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_Y, 32'd360, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd100, -16'sd200, 16'sd300, 1,
                          '{32'sd25600, -32'sd51200, 32'sd76800}});
        // Largest scale with 45 degree turns pushes the rotations into saturation.
        steps.push_back('{1, REG_X_SCALE, 32'hFFFF, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_Y_SCALE, 32'hFFFF, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_Z_SCALE, 32'hFFFF, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_X, 32'd45, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_Y, 32'd45, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_Z, 32'd45, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd32767, 16'sd32767, 16'sd32767, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, -16'sd32768, -16'sd32768, -16'sd32768, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd32767, -16'sd32768, 16'sd32767, 0, '0});
        // Offsets at their limits saturate the final X and Y sums.
        steps.push_back('{1, REG_ANGLE_X, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_Y, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_Z, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_SHIFT_X, 32'h7FFF, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_SHIFT_Y, 32'hFFFF_8000, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd32767, -16'sd32768, -16'sd32768, 1,
                          '{32'sh7FFFFFFF, 32'sh80000000, -32'sd2147450880}});
        steps.push_back('{1, REG_X_SCALE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_Y_SCALE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_Z_SCALE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, -16'sd32768, 16'sd32767, -16'sd1, 1,
                          '{32'sd8388352, -32'sd8388608, 32'sd0}});
        steps.push_back('{1, REG_SHIFT_X, 32'h8000, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_SHIFT_Y, 32'h7FFF, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_X_SCALE, 32'd128, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_Y_SCALE, 32'd1, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_Z_SCALE, 32'hFFFF, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_Z, 32'd30, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_X, 32'd330, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{1, REG_ANGLE_Y, 32'd200, 16'sd0, 16'sd0, 16'sd0, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, -16'sd1, 16'sd1, -16'sd1, 0, '0});
        steps.push_back('{0, 3'd0, 32'd0, 16'sd32767, -16'sd32768, 16'sd32767, 0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            st = steps[i];
            if (st.is_write)
            begin
                drain();
                program_reg(st.idx, st.value);
            end
            else
            begin
                want = st.typed ? st.want : predict_vertex(st.px, st.py, st.pz);
                send_point(st.px, st.py, st.pz, want);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            logic [31:0] noise;
            logic [15:0] sc [3];
            logic [8:0]  an [3];
            logic [15:0] sh [2];
            drain();
            for (int k = 0; k < 3; k++)
            begin
                sc[k] = pick_scale();
                an[k] = pick_angle();
            end
            sh[0] = pick_shift();
            sh[1] = pick_shift();
            // The first two settings use top and bottom values, 359 as the top angle.
            if (ph == 0)
            begin
                sc = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
                an = '{9'd359, 9'd359, 9'd359};
                sh = '{16'h7FFF, 16'h7FFF};
            end
            else if (ph == 1)
            begin
                sc = '{16'd0, 16'd0, 16'd0};
                an = '{9'd0, 9'd0, 9'd0};
                sh = '{16'h8000, 16'h8000};
            end
            // Upper data bits carry noise that the registers must drop.
            noise = $urandom();
            program_reg(REG_X_SCALE, {noise[31:16], sc[0]});
            program_reg(REG_Y_SCALE, {noise[15:0], sc[1]});
            program_reg(REG_Z_SCALE, {noise[23:8], sc[2]});
            program_reg(REG_ANGLE_X, {noise[31:9], an[0]});
            program_reg(REG_ANGLE_Y, {noise[22:0], an[1]});
            program_reg(REG_ANGLE_Z, {noise[27:5], an[2]});
            program_reg(REG_SHIFT_X, {noise[31:16], sh[0]});
            program_reg(REG_SHIFT_Y, {noise[15:0], sh[1]});
            gaps_on = (ph != 2);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
            begin
                logic signed [15:0] rx;
                logic signed [15:0] ry;
                logic signed [15:0] rz;
                rx = pick_coord();
                ry = pick_coord();
                rz = pick_coord();
                send_point(rx, ry, rz, predict_vertex(rx, ry, rz));
            end
        end
        gaps_on = 1'b1;
        drain();

        $display("Sent %0d points and checked %0d results over %0d register writes,",
                 points_sent, points_checked, reg_writes);
        $display("covering angle wrap, rotation and offset saturation, and scale extremes.");
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
